// ----- rtl/ctn_pkg.sv -----
// Shared types, constants and lookup functions for the camera-to-NED transform.
// Used by every module of the block; depends on nothing.
package ctn_pkg;

    localparam int CW = 33;      // CORDIC x/y width, Q30
    localparam int ZW = 34;      // CORDIC angle accumulator width, Q30
    localparam int MAX_STEPS = 24;

    localparam logic signed [19:0] ANG_PI      = 20'sd205887;
    localparam logic signed [19:0] ANG_HALF_PI = 20'sd102944;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;

    localparam logic signed [31:0] DEPTH_LO = 32'sd49152;
    localparam logic signed [31:0] DEPTH_HI = 32'sd311296;
    localparam logic [4:0] MAX_LEVEL = 5'd18;

    localparam logic [1:0] REG_OFFSET_X = 2'd0;
    localparam logic [1:0] REG_OFFSET_Y = 2'd1;
    localparam logic [1:0] REG_OFFSET_Z = 2'd2;

    localparam logic signed [31:0] OFFSET_X_RST = 32'sd45548;
    localparam logic signed [31:0] OFFSET_Y_RST = 32'sd0;
    localparam logic signed [31:0] OFFSET_Z_RST = 32'sd9830;

    // tan^2 of the band edges 7.2, 14.4, ... 36 degrees, Q24
    localparam logic [23:0] TAN2_Q24 [5] = '{24'd267749, 24'd1106018, 24'd2629981,
                                             24'd5070565, 24'd8856088};

    localparam logic [4:0] LEVEL_TABLE [5][16] = '{
        '{5'd1, 5'd1, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6,
          5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14},
        '{5'd1, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7,
          5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15},
        '{5'd2, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8,
          5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16},
        '{5'd4, 5'd4, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9,
          5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17},
        '{5'd6, 5'd6, 5'd6, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10,
          5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18}
    };

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 neg;
    } cordic_t;

    typedef struct packed {
        logic signed [32:0] bx;
        logic signed [32:0] by;
        logic signed [32:0] bz;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
    } side_t;

    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] v;
        begin
            unique case (i)
                0:  v = 32'h3243F6A8;
                1:  v = 32'h1DAC6705;
                2:  v = 32'h0FADBAFC;
                3:  v = 32'h07F56EA6;
                4:  v = 32'h03FEAB76;
                5:  v = 32'h01FFD55B;
                6:  v = 32'h00FFFAAA;
                7:  v = 32'h007FFF55;
                8:  v = 32'h003FFFEA;
                9:  v = 32'h001FFFFD;
                10: v = 32'h000FFFFF;
                11: v = 32'h0007FFFF;
                12: v = 32'h0003FFFF;
                13: v = 32'h0001FFFF;
                14: v = 32'h0000FFFF;
                15: v = 32'h00007FFF;
                16: v = 32'h00003FFF;
                17: v = 32'h00001FFF;
                18: v = 32'h00000FFF;
                19: v = 32'h000007FF;
                20: v = 32'h000003FF;
                21: v = 32'h000001FF;
                22: v = 32'h000000FF;
                default: v = 32'h0000007F;
            endcase
            return v;
        end
    endfunction

    // Q30 x Q30 product, rounded to Q30
    function automatic logic signed [31:0] mul30(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [63:0] p;
        begin
            p = a * b + 64'sd536870912;
            return p[61:30];
        end
    endfunction

endpackage

// ----- rtl/ctn_cordic_cell.sv -----
// One CORDIC rotation step for the three Euler angles, plus the item's side data.
// Depends on ctn_pkg.
module ctn_cordic_cell import ctn_pkg::*; #(
    parameter int SHIFT = 0
) (
    input  logic              clk,
    input  logic              en,
    input  cordic_t [2:0]     cs_in,
    input  side_t             side_in,
    output cordic_t [2:0]     cs_out,
    output side_t             side_out
);

    localparam logic signed [ZW-1:0] ATAN = signed'({2'b00, atan_q30(SHIFT)});

    cordic_t [2:0] cs_reg, cs_next;
    side_t         side_reg;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            cs_next[a].neg = cs_in[a].neg;
            if (!cs_in[a].z[ZW-1])
            begin
                cs_next[a].x = cs_in[a].x - (cs_in[a].y >>> SHIFT);
                cs_next[a].y = cs_in[a].y + (cs_in[a].x >>> SHIFT);
                cs_next[a].z = cs_in[a].z - ATAN;
            end
            else
            begin
                cs_next[a].x = cs_in[a].x + (cs_in[a].y >>> SHIFT);
                cs_next[a].y = cs_in[a].y - (cs_in[a].x >>> SHIFT);
                cs_next[a].z = cs_in[a].z + ATAN;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cs_reg   <= cs_next;
            side_reg <= side_in;
        end
    end

    assign cs_out   = cs_reg;
    assign side_out = side_reg;

endmodule

// ----- rtl/ctn_matrix.sv -----
// Builds the ZYX rotation matrix from sine/cosine and rotates the body vector.
// Five register stages; depends on ctn_pkg.
module ctn_matrix import ctn_pkg::*; (
    input  logic               clk,
    input  logic               en,
    input  cordic_t [2:0]      cs,
    input  logic signed [32:0] bx,
    input  logic signed [32:0] by,
    input  logic signed [32:0] bz,
    output logic signed [31:0] ned_x,
    output logic signed [31:0] ned_y,
    output logic signed [31:0] ned_z
);

    logic signed [31:0] sn [3];
    logic signed [31:0] cs_v [3];
    logic signed [32:0] tmp_s, tmp_c;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            tmp_s = cs[a].neg ? -cs[a].y : cs[a].y;
            tmp_c = cs[a].neg ? -cs[a].x : cs[a].x;
            sn[a]   = tmp_s[31:0];
            cs_v[a] = tmp_c[31:0];
        end
    end

    // stage 1: first-order products
    logic signed [31:0] cycz_reg, cxsz_reg, cysz_reg, cxcz_reg, sxsz_reg, sxcz_reg;
    logic signed [31:0] sxcy_reg, cxcy_reg, sxsy_reg, cxsy_reg, sy1_reg, sz1_reg, cz1_reg;
    logic signed [32:0] b1_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cycz_reg <= mul30(cs_v[1], cs_v[2]);
            cxsz_reg <= mul30(cs_v[0], sn[2]);
            cysz_reg <= mul30(cs_v[1], sn[2]);
            cxcz_reg <= mul30(cs_v[0], cs_v[2]);
            sxsz_reg <= mul30(sn[0], sn[2]);
            sxcz_reg <= mul30(sn[0], cs_v[2]);
            sxcy_reg <= mul30(sn[0], cs_v[1]);
            cxcy_reg <= mul30(cs_v[0], cs_v[1]);
            sxsy_reg <= mul30(sn[0], sn[1]);
            cxsy_reg <= mul30(cs_v[0], sn[1]);
            sy1_reg  <= sn[1];
            sz1_reg  <= sn[2];
            cz1_reg  <= cs_v[2];
            b1_reg[0] <= bx;
            b1_reg[1] <= by;
            b1_reg[2] <= bz;
        end
    end

    // stage 2: second-order products
    logic signed [31:0] p_sxsycz_reg, p_cxsycz_reg, p_sxsysz_reg, p_cxsysz_reg;
    logic signed [31:0] cycz2_reg, cxsz2_reg, cysz2_reg, cxcz2_reg, sxsz2_reg, sxcz2_reg;
    logic signed [31:0] sxcy2_reg, cxcy2_reg, sy2_reg;
    logic signed [32:0] b2_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_sxsycz_reg <= mul30(sxsy_reg, cz1_reg);
            p_cxsycz_reg <= mul30(cxsy_reg, cz1_reg);
            p_sxsysz_reg <= mul30(sxsy_reg, sz1_reg);
            p_cxsysz_reg <= mul30(cxsy_reg, sz1_reg);
            cycz2_reg <= cycz_reg;
            cxsz2_reg <= cxsz_reg;
            cysz2_reg <= cysz_reg;
            cxcz2_reg <= cxcz_reg;
            sxsz2_reg <= sxsz_reg;
            sxcz2_reg <= sxcz_reg;
            sxcy2_reg <= sxcy_reg;
            cxcy2_reg <= cxcy_reg;
            sy2_reg   <= sy1_reg;
            b2_reg    <= b1_reg;
        end
    end

    // stage 3: matrix entries, rounded from Q30 to Q28
    logic signed [32:0] r_ent [9];
    logic signed [32:0] q_ent [9];
    logic signed [31:0] q_reg [9];
    logic signed [32:0] b3_reg [3];

    always_comb
    begin
        r_ent[0] = 33'(cycz2_reg);
        r_ent[1] = 33'(p_sxsycz_reg) - 33'(cxsz2_reg);
        r_ent[2] = 33'(p_cxsycz_reg) + 33'(sxsz2_reg);
        r_ent[3] = 33'(cysz2_reg);
        r_ent[4] = 33'(p_sxsysz_reg) + 33'(cxcz2_reg);
        r_ent[5] = 33'(p_cxsysz_reg) - 33'(sxcz2_reg);
        r_ent[6] = -33'(sy2_reg);
        r_ent[7] = 33'(sxcy2_reg);
        r_ent[8] = 33'(cxcy2_reg);
        for (int k = 0; k < 9; k++)
        begin
            q_ent[k] = (r_ent[k] + 33'sd2) >>> 2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 9; k++)
            begin
                q_reg[k] <= q_ent[k][31:0];
            end
            b3_reg <= b2_reg;
        end
    end

    // stage 4: vector times matrix entries
    logic signed [63:0] prod_next [9];
    logic signed [63:0] prod_reg [9];

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            prod_next[k] = b3_reg[k % 3] * q_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 9; k++)
            begin
                prod_reg[k] <= prod_next[k];
            end
        end
    end

    // stage 5: row sums, round to Q16, saturate
    logic signed [65:0] acc [3];
    logic signed [37:0] shifted [3];
    logic signed [31:0] sat [3];
    logic signed [31:0] ned_reg [3];

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            acc[j] = 66'(prod_reg[3*j]) + 66'(prod_reg[3*j+1]) + 66'(prod_reg[3*j+2])
                   + 66'sd134217728;
            shifted[j] = acc[j][65:28];
            if (shifted[j] > 38'sd2147483647)
                sat[j] = 32'sh7FFFFFFF;
            else if (shifted[j] < -38'sd2147483648)
                sat[j] = 32'sh80000000;
            else
                sat[j] = shifted[j][31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ned_reg <= sat;
        end
    end

    assign ned_x = ned_reg[0];
    assign ned_y = ned_reg[1];
    assign ned_z = ned_reg[2];

endmodule

// ----- rtl/ctn_accuracy.sv -----
// Accuracy grading from depth band and off-axis angle band.
// Five register stages to line up with ctn_matrix; depends on ctn_pkg.
module ctn_accuracy import ctn_pkg::*; (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] cx,
    input  logic signed [31:0] cy,
    input  logic signed [31:0] cz,
    output logic [4:0]         grade
);

    // stage 1: squares and depth band
    logic [63:0] r2_reg;
    logic [37:0] z2_reg;
    logic [3:0]  col_reg;
    logic        inr_reg;
    logic [18:0] zdiff;
    logic signed [63:0] sq_x, sq_y;

    assign zdiff = cz[18:0] - DEPTH_LO[18:0];
    assign sq_x  = cx * cx;
    assign sq_y  = cy * cy;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r2_reg  <= sq_x + sq_y;
            z2_reg  <= cz[18:0] * cz[18:0];
            col_reg <= zdiff[17:14];
            inr_reg <= (cz > DEPTH_LO) && (cz < DEPTH_HI);
        end
    end

    // stage 2: band edges
    logic [37:0] edge_reg [5];
    logic [63:0] r2b_reg;
    logic [3:0]  colb_reg;
    logic        inrb_reg;
    logic [61:0] eprod [5];

    always_comb
    begin
        for (int k = 0; k < 5; k++)
        begin
            eprod[k] = z2_reg * TAN2_Q24[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 5; k++)
            begin
                edge_reg[k] <= eprod[k][61:24];
            end
            r2b_reg  <= r2_reg;
            colb_reg <= col_reg;
            inrb_reg <= inr_reg;
        end
    end

    // stage 3: row count and table read
    logic [2:0] row;
    logic       ok;
    logic [4:0] lvl_next;
    logic [4:0] lvl_reg [3];

    always_comb
    begin
        row = 3'd0;
        for (int k = 0; k < 4; k++)
        begin
            if (r2b_reg >= 64'(edge_reg[k]))
                row = row + 3'd1;
        end
        ok = inrb_reg && (r2b_reg != 64'd0) && (r2b_reg < 64'(edge_reg[4]));
        lvl_next = ok ? LEVEL_TABLE[row][colb_reg] : 5'd0;
    end

    // stages 3..5: hold the level alongside the matrix pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lvl_reg[0] <= lvl_next;
            lvl_reg[1] <= lvl_reg[0];
            lvl_reg[2] <= lvl_reg[1];
        end
    end

    assign grade = lvl_reg[2];

endmodule

// ----- rtl/camera_to_ned_transform.sv -----
// Camera-to-NED transform top level: input stage, CORDIC cell chain, matrix and grading.
// Depends on ctn_pkg, ctn_cordic_cell, ctn_matrix and ctn_accuracy.
// The block takes one item per clock while in_stall is low and returns one result
// per item, in order. It has one input stage, one CORDIC cell per iteration (capped
// at MAX_STEPS; all three angles rotate side by side), and five stages for the matrix
// products, row sums and output register. The whole pipeline holds while a result waits
// under out_stall, so in_stall follows out_stall whenever a result is presented.
// Offsets are read at the input stage; write them only while the pipeline is empty.
module camera_to_ned_transform import ctn_pkg::*; #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] cam_x,
    input  logic signed [31:0] cam_y,
    input  logic signed [31:0] cam_z,
    input  logic signed [18:0] roll,
    input  logic signed [18:0] pitch,
    input  logic signed [18:0] yaw,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] ned_x,
    output logic signed [31:0] ned_y,
    output logic signed [31:0] ned_z,
    output logic [4:0]         grade
);

    localparam int STEPS = (CORDIC_ITERATIONS > MAX_STEPS) ? MAX_STEPS : CORDIC_ITERATIONS;
    localparam int DEPTH = STEPS + 6;

    logic signed [31:0] off_x_reg, off_y_reg, off_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_x_reg <= OFFSET_X_RST;
            off_y_reg <= OFFSET_Y_RST;
            off_z_reg <= OFFSET_Z_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OFFSET_X: off_x_reg <= cfg_data;
                REG_OFFSET_Y: off_y_reg <= cfg_data;
                REG_OFFSET_Z: off_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic adv;
    logic [DEPTH-1:0] vld_reg;

    assign adv      = !(vld_reg[DEPTH-1] && out_stall);
    assign in_stall = !adv;
    assign out_valid = vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
    end

    // input stage: angle reduction to +-pi/2 and body-frame vector
    cordic_t [2:0] cs0_next;
    cordic_t [2:0] cs0_reg;
    side_t         side0_next, side0_reg;
    logic signed [19:0] ang [3];
    logic signed [19:0] red;

    always_comb
    begin
        ang[0] = 20'(roll);
        ang[1] = 20'(pitch);
        ang[2] = 20'(yaw);
        for (int a = 0; a < 3; a++)
        begin
            priority if (ang[a] > ANG_HALF_PI)
            begin
                red = ang[a] - ANG_PI;
                cs0_next[a].neg = 1'b1;
            end
            else if (ang[a] < -ANG_HALF_PI)
            begin
                red = ang[a] + ANG_PI;
                cs0_next[a].neg = 1'b1;
            end
            else
            begin
                red = ang[a];
                cs0_next[a].neg = 1'b0;
            end
            cs0_next[a].x = CORDIC_GAIN;
            cs0_next[a].y = '0;
            cs0_next[a].z = {red, 14'd0};
        end
        side0_next.bx = 33'(cam_z) + 33'(off_x_reg);
        side0_next.by = 33'(cam_x) + 33'(off_y_reg);
        side0_next.bz = 33'(cam_y) + 33'(off_z_reg);
        side0_next.cx = cam_x;
        side0_next.cy = cam_y;
        side0_next.cz = cam_z;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cs0_reg   <= cs0_next;
            side0_reg <= side0_next;
        end
    end

    cordic_t [2:0] cs_chain [STEPS+1];
    side_t         side_chain [STEPS+1];

    assign cs_chain[0]   = cs0_reg;
    assign side_chain[0] = side0_reg;

    for (genvar g = 0; g < STEPS; g++)
    begin : g_cell
        ctn_cordic_cell #(
            .SHIFT(g)
        ) u_cell (
            .clk     (clk),
            .en      (adv),
            .cs_in   (cs_chain[g]),
            .side_in (side_chain[g]),
            .cs_out  (cs_chain[g+1]),
            .side_out(side_chain[g+1])
        );
    end

    ctn_matrix u_matrix (
        .clk  (clk),
        .en   (adv),
        .cs   (cs_chain[STEPS]),
        .bx   (side_chain[STEPS].bx),
        .by   (side_chain[STEPS].by),
        .bz   (side_chain[STEPS].bz),
        .ned_x(ned_x),
        .ned_y(ned_y),
        .ned_z(ned_z)
    );

    ctn_accuracy u_accuracy (
        .clk  (clk),
        .en   (adv),
        .cx   (side_chain[STEPS].cx),
        .cy   (side_chain[STEPS].cy),
        .cz   (side_chain[STEPS].cz),
        .grade(grade)
    );

    a_empty_stays_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(vld_reg) == 0 && !in_valid) |=> !out_valid)
        else $error("result appeared from an empty pipeline");

    a_advance_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && vld_reg[DEPTH-2]) |=> out_valid)
        else $error("item lost at output stage");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (grade <= MAX_LEVEL))
        else $error("accuracy level out of range");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(vld_reg) && out_valid))
        else $error("pipeline moved while output stalled");

endmodule
